/* sv/dmpc_pkg.sv */
`timescale 1ns / 1ps

package dmpc_pkg;

    // field widths
    localparam int POS_W   = 32;
    localparam int GAIN_W  = 16;
    localparam int SCALE_W = 18;
    localparam int INTEG_W = 17;
    localparam int DUTY_W  = 16;
    localparam int MAG_W   = 17;
    localparam int MUL_A_W = 34;
    localparam int ACC_W   = 53;
    localparam int PC_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 40;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SCALE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY_FS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_DONE_THRESH = 3'd5;

    // register defaults
    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN   = 16'd19661;
    localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN  = 16'd66;
    localparam logic [GAIN_W-1:0]  RST_INTEG_LIMIT = 16'd1000;
    localparam logic [SCALE_W-1:0] RST_SPEED_SCALE = 18'd65536;
    localparam logic [GAIN_W-1:0]  RST_DUTY_FS     = 16'd1000;
    localparam logic [GAIN_W-1:0]  RST_DONE_THRESH = 16'd2;

    // item kinds
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // q16 unity speed
    localparam logic signed [ACC_W-1:0] SPEED_ONE = 53'sd65536;

    // program addresses
    localparam logic [PC_W-1:0] PC_START_MOVE = 5'd18;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_START,
        OP_ERR,
        OP_INT,
        OP_MULP,
        OP_MACI,
        OP_SAT,
        OP_MULF,
        OP_MULS,
        OP_DUTY,
        OP_OUT
    } t_op;

    typedef enum logic [1:0] {
        CND_NEXT,
        CND_IF_START,
        CND_END
    } t_cond;

    typedef enum logic {
        S_IDLE,
        S_RUN
    } t_seq_state;

    typedef struct packed {
        t_op             op;
        logic            wheel;
        t_cond           cond;
        logic [PC_W-1:0] target;
    } t_ctl_word;

    typedef struct packed {
        logic en;
        t_op  op;
        logic wheel;
    } t_ctl;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  integ_limit;
        logic [SCALE_W-1:0] speed_scale;
        logic [GAIN_W-1:0]  duty_full_scale;
        logic [GAIN_W-1:0]  done_threshold;
    } t_cfg;

    typedef struct packed {
        logic             kind;
        logic [POS_W-1:0] left_position;
        logic [POS_W-1:0] right_position;
        logic [POS_W-1:0] left_move;
        logic [POS_W-1:0] right_move;
    } t_item;

    typedef struct packed {
        logic              left_forward;
        logic              right_forward;
        logic [DUTY_W-1:0] left_duty;
        logic [DUTY_W-1:0] right_duty;
        logic              done_res;
    } t_result;

    // microcode store: wheel 0 at 1..8, wheel 1 at 9..16
    function automatic t_ctl_word ucode_rom(input logic [PC_W-1:0] pc);
        t_ctl_word w;
        w = '{op: OP_NOP, wheel: 1'b0, cond: CND_NEXT, target: '0};
        case (pc)
            5'd0:  w = '{op: OP_NOP,  wheel: 1'b0, cond: CND_IF_START, target: PC_START_MOVE};
            5'd1:  w.op = OP_ERR;
            5'd2:  w.op = OP_INT;
            5'd3:  w.op = OP_MULP;
            5'd4:  w.op = OP_MACI;
            5'd5:  w.op = OP_SAT;
            5'd6:  w.op = OP_MULF;
            5'd7:  w.op = OP_MULS;
            5'd8:  w.op = OP_DUTY;
            5'd9:  w = '{op: OP_ERR,  wheel: 1'b1, cond: CND_NEXT, target: '0};
            5'd10: w = '{op: OP_INT,  wheel: 1'b1, cond: CND_NEXT, target: '0};
            5'd11: w = '{op: OP_MULP, wheel: 1'b1, cond: CND_NEXT, target: '0};
            5'd12: w = '{op: OP_MACI, wheel: 1'b1, cond: CND_NEXT, target: '0};
            5'd13: w = '{op: OP_SAT,  wheel: 1'b1, cond: CND_NEXT, target: '0};
            5'd14: w = '{op: OP_MULF, wheel: 1'b1, cond: CND_NEXT, target: '0};
            5'd15: w = '{op: OP_MULS, wheel: 1'b1, cond: CND_NEXT, target: '0};
            5'd16: w = '{op: OP_DUTY, wheel: 1'b1, cond: CND_NEXT, target: '0};
            5'd17: w = '{op: OP_OUT,  wheel: 1'b0, cond: CND_END,  target: '0};
            5'd18: w = '{op: OP_START, wheel: 1'b0, cond: CND_NEXT, target: '0};
            5'd19: w = '{op: OP_OUT,  wheel: 1'b0, cond: CND_END,  target: '0};
            default: w = '{op: OP_NOP, wheel: 1'b0, cond: CND_END, target: '0};
        endcase
        return w;
    endfunction

endpackage

/* sv/dmpc_seq.sv */
`timescale 1ns / 1ps

module dmpc_seq
    import dmpc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  logic i_kind,
    input  logic i_out_free,
    output logic o_idle,
    output t_ctl o_ctl
);

    t_seq_state      r_state, n_state;
    logic [PC_W-1:0] r_pc, n_pc;
    t_ctl_word       w_word;
    logic            w_stall;

    // current control word
    assign w_word  = ucode_rom(r_pc);
    assign w_stall = (w_word.op == OP_OUT) && !i_out_free;

    // next state and step counter
    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_RUN;
                    n_pc    = '0;
                end
            end
            S_RUN: begin
                if (!w_stall) begin
                    case (w_word.cond)
                        CND_IF_START: n_pc = (i_kind == KIND_START) ? w_word.target
                                                                    : r_pc + 1'b1;
                        CND_END:      n_state = S_IDLE;
                        default:      n_pc = r_pc + 1'b1;
                    endcase
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_idle = 1'b0;
        o_ctl  = '{en: 1'b0, op: w_word.op, wheel: w_word.wheel};
        unique case (r_state)
            S_IDLE:  o_idle = 1'b1;
            S_RUN:   o_ctl.en = !w_stall;
            default: o_idle = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

endmodule

/* sv/dmpc_dp.sv */
`timescale 1ns / 1ps

module dmpc_dp
    import dmpc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ctl    i_ctl,
    input  t_cfg    i_cfg,
    input  t_item   i_item,
    output t_result o_result
);

    logic [POS_W-1:0]          r_goal  [2];
    logic signed [INTEG_W-1:0] r_integ [2];
    logic [DUTY_W-1:0]         r_duty  [2];
    logic [1:0]                r_fwd;
    logic [1:0]                r_near;
    logic signed [POS_W-1:0]   r_err;
    logic signed [INTEG_W-1:0] r_sum;
    logic signed [ACC_W-1:0]   r_acc;
    logic [MAG_W-1:0]          r_mag;

    logic                       w;
    logic [POS_W-1:0]           w_pos;
    logic signed [MUL_A_W-1:0]  w_sum_ext;
    logic signed [MUL_A_W-1:0]  w_lim_pos;
    logic signed [MUL_A_W-1:0]  w_lim_neg;
    logic signed [INTEG_W-1:0]  w_sum_sat;
    logic [POS_W:0]             w_err_abs;
    logic signed [MUL_A_W-1:0]  w_mul_a;
    logic [SCALE_W-1:0]         w_mul_b;
    logic signed [ACC_W-1:0]    w_mul_p;
    logic signed [ACC_W-1:0]    w_acc_neg;
    logic [ACC_W-POS_W-1:0]     w_duty_raw;
    logic [ACC_W-POS_W-1:0]     w_fs_ext;

    assign w     = i_ctl.wheel;
    assign w_pos = w ? i_item.right_position : i_item.left_position;

    // integral update with symmetric saturation
    assign w_sum_ext = {{(MUL_A_W-INTEG_W){r_integ[w][INTEG_W-1]}}, r_integ[w]}
                     + {{(MUL_A_W-POS_W){r_err[POS_W-1]}}, r_err};
    assign w_lim_pos = $signed({{(MUL_A_W-GAIN_W){1'b0}}, i_cfg.integ_limit});
    assign w_lim_neg = -w_lim_pos;
    always_comb begin
        if (w_sum_ext > w_lim_pos) begin
            w_sum_sat = w_lim_pos[INTEG_W-1:0];
        end else if (w_sum_ext < w_lim_neg) begin
            w_sum_sat = w_lim_neg[INTEG_W-1:0];
        end else begin
            w_sum_sat = w_sum_ext[INTEG_W-1:0];
        end
    end

    // error magnitude for the done test
    assign w_err_abs = r_err[POS_W-1] ? ({(POS_W+1){1'b0}} - {1'b1, r_err})
                                      : {1'b0, r_err};

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_ctl.op)
            OP_MULP: begin
                w_mul_a = {{(MUL_A_W-POS_W){r_err[POS_W-1]}}, r_err};
                w_mul_b = {{(SCALE_W-GAIN_W){1'b0}}, i_cfg.prop_gain};
            end
            OP_MACI: begin
                w_mul_a = {{(MUL_A_W-INTEG_W){r_sum[INTEG_W-1]}}, r_sum};
                w_mul_b = {{(SCALE_W-GAIN_W){1'b0}}, i_cfg.integ_gain};
            end
            OP_MULF: begin
                w_mul_a = {{(MUL_A_W-MAG_W){1'b0}}, r_mag};
                w_mul_b = {{(SCALE_W-GAIN_W){1'b0}}, i_cfg.duty_full_scale};
            end
            OP_MULS: begin
                w_mul_a = {1'b0, r_acc[POS_W:0]};
                w_mul_b = i_cfg.speed_scale;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p    = w_mul_a * $signed({1'b0, w_mul_b});
    assign w_acc_neg  = -r_acc;
    assign w_duty_raw = r_acc[ACC_W-1:POS_W];
    assign w_fs_ext   = {{(ACC_W-POS_W-GAIN_W){1'b0}}, i_cfg.duty_full_scale};

    // datapath registers, one micro-op per cycle while the control word is enabled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal[0]  <= '0;
            r_goal[1]  <= '0;
            r_integ[0] <= '0;
            r_integ[1] <= '0;
            r_duty[0]  <= '0;
            r_duty[1]  <= '0;
            r_fwd      <= '0;
            r_near     <= '0;
            r_err      <= '0;
            r_sum      <= '0;
            r_acc      <= '0;
            r_mag      <= '0;
        end else if (i_ctl.en) begin
            case (i_ctl.op)
                OP_START: begin
                    r_goal[0]  <= i_item.left_position + i_item.left_move;
                    r_goal[1]  <= i_item.right_position + i_item.right_move;
                    r_integ[0] <= '0;
                    r_integ[1] <= '0;
                    r_fwd      <= {!i_item.right_move[POS_W-1], !i_item.left_move[POS_W-1]};
                    r_near     <= '0;
                end
                OP_ERR:  r_err <= r_goal[w] - w_pos;
                OP_INT: begin
                    r_sum      <= w_sum_sat;
                    r_integ[w] <= w_sum_sat;
                    r_near[w]  <= w_err_abs < {{(POS_W+1-GAIN_W){1'b0}},
                                              i_cfg.done_threshold};
                end
                OP_MULP: r_acc <= w_mul_p;
                OP_MACI: r_acc <= r_acc + w_mul_p;
                OP_SAT: begin
                    if (r_acc > SPEED_ONE) begin
                        r_mag    <= SPEED_ONE[MAG_W-1:0];
                        r_fwd[w] <= 1'b1;
                    end else if (r_acc < -SPEED_ONE) begin
                        r_mag    <= SPEED_ONE[MAG_W-1:0];
                        r_fwd[w] <= 1'b0;
                    end else begin
                        r_mag    <= r_acc[ACC_W-1] ? w_acc_neg[MAG_W-1:0]
                                                   : r_acc[MAG_W-1:0];
                        r_fwd[w] <= !r_acc[ACC_W-1];
                    end
                end
                OP_MULF: r_acc <= w_mul_p;
                OP_MULS: r_acc <= w_mul_p;
                OP_DUTY: begin
                    r_duty[w] <= (w_duty_raw > w_fs_ext) ? i_cfg.duty_full_scale
                                                         : w_duty_raw[DUTY_W-1:0];
                end
                default: r_acc <= r_acc;
            endcase
        end
    end

    assign o_result = '{left_forward:  r_fwd[0],
                        right_forward: r_fwd[1],
                        left_duty:     r_duty[0],
                        right_duty:    r_duty[1],
                        done_res:      &r_near};

    // integral stays inside its bound after an update
    a_integ_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.en && i_ctl.op == OP_INT) |=>
            ($signed(r_sum) <= $signed({1'b0, $past(i_cfg.integ_limit)}) &&
             $signed(r_sum) >= -$signed({1'b0, $past(i_cfg.integ_limit)})))
        else $error("integral outside limit");

    // saturated speed magnitude never exceeds one
    a_mag_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.en && i_ctl.op == OP_SAT) |=> (r_mag <= SPEED_ONE[MAG_W-1:0]))
        else $error("speed magnitude above unity");

    // duty clamped to full scale
    a_duty_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.en && i_ctl.op == OP_DUTY) |=>
            (r_duty[$past(i_ctl.wheel)] <= $past(i_cfg.duty_full_scale)))
        else $error("duty above full scale");

endmodule

/* sv/dual_motor_position_pi_control.sv */
`timescale 1ns / 1ps

// control step: the wheels run in turn, then the result is written to the output
// register, one shared 34x19 multiplier used four times per wheel in sequence
// start move: targets and directions are set and integrals cleared before the result
// a new item is taken the cycle after the program ends
// synchronous active-low reset restores register defaults, clears targets,
// integrals and held duties and empties the output register

module dual_motor_position_pi_control
    import dmpc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // config write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [SCALE_W-1:0]    i_cfg_data,
    // input stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // left_position, right_position, left_move, right_move
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic                  s_axis_tuser,
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // left_forward, right_forward, left_duty, right_duty, done_res, zero pad
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    t_cfg    r_cfg;
    t_item   r_item;
    t_result w_result;
    t_result r_out;
    logic    r_out_valid;
    logic    w_idle;
    logic    w_in_xfer;
    logic    w_out_free;
    t_ctl    w_ctl;

    assign s_axis_tready = w_idle;
    assign w_in_xfer     = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{prop_gain:       RST_PROP_GAIN,
                       integ_gain:      RST_INTEG_GAIN,
                       integ_limit:     RST_INTEG_LIMIT,
                       speed_scale:     RST_SPEED_SCALE,
                       duty_full_scale: RST_DUTY_FS,
                       done_threshold:  RST_DONE_THRESH};
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:   r_cfg.prop_gain       <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:  r_cfg.integ_gain      <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_LIMIT: r_cfg.integ_limit     <= i_cfg_data[GAIN_W-1:0];
                CFG_SPEED_SCALE: r_cfg.speed_scale     <= i_cfg_data;
                CFG_DUTY_FS:     r_cfg.duty_full_scale <= i_cfg_data[GAIN_W-1:0];
                CFG_DONE_THRESH: r_cfg.done_threshold  <= i_cfg_data[GAIN_W-1:0];
                default:         r_cfg <= r_cfg;
            endcase
        end
    end

    // input capture
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_item <= '{kind:           s_axis_tuser,
                        left_position:  s_axis_tdata[31:0],
                        right_position: s_axis_tdata[63:32],
                        left_move:      s_axis_tdata[95:64],
                        right_move:     s_axis_tdata[127:96]};
        end
    end

    dmpc_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_xfer),
        .i_kind     (r_item.kind),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_ctl      (w_ctl)
    );

    dmpc_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_cfg    (r_cfg),
        .i_item   (r_item),
        .o_result (w_result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_ctl.en && w_ctl.op == OP_OUT) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ctl.en && w_ctl.op == OP_OUT) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{(OUT_DATA_W-35){1'b0}},
                            r_out.done_res,
                            r_out.right_duty,
                            r_out.left_duty,
                            r_out.right_forward,
                            r_out.left_forward};

    // one item in flight at a time
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !s_axis_tready)
        else $error("input taken while program running");

    // a result is never written over one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_ctl.en && w_ctl.op == OP_OUT) |-> (!r_out_valid || m_axis_tready))
        else $error("result overwritten");

endmodule

/* tb/tb_dual_motor_position_pi_control.sv */
`timescale 1ns / 1ps

module tb_dual_motor_position_pi_control;
    import dmpc_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RST_CYCLES  = 7;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 25;
    localparam int N_PHASES    = 10;
    localparam int PHASE_ITEMS = 104;

    // indexes past the register list, ignored by the block
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [SCALE_W-1:0]    i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // left_position, right_position, left_move, right_move
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // kind
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // left_forward, right_forward, left_duty, right_duty, done_res, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    dual_motor_position_pi_control dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // controller shadow: registers and per-wheel state
    logic [GAIN_W-1:0]  kp_m, ki_m, ilim_m, fs_m, thr_m;
    logic [SCALE_W-1:0] scale_m;
    logic [POS_W-1:0]   l_goal, r_goal;
    longint             l_integ, r_integ;
    logic [DUTY_W-1:0]  l_duty_held, r_duty_held;

    // targets as seen by the item generator
    logic [POS_W-1:0]   gen_lgoal, gen_rgoal;

    t_item   move_q[$];
    t_result motor_cmd_q[$];
    t_item   drv_item;
    int      drv_gap, mon_gap, idle_cycles, n_errors;
    bit      quiet;

    function automatic int draw_gap();
        return quiet ? 0 : int'($urandom_range(0, 3));
    endfunction

    // one wheel of the pi loop, returns the signed position error
    function automatic longint pi_wheel(input logic [POS_W-1:0] goal,
                                        input logic [POS_W-1:0] pos,
                                        inout longint integ,
                                        output logic fwd,
                                        output logic [DUTY_W-1:0] duty);
        logic [POS_W-1:0]  diff;
        longint            err, lim, sum, spd;
        longint unsigned   mag, d;
        diff = goal - pos;
        err = longint'($signed(diff));
        lim = longint'(ilim_m);
        sum = integ + err;
        if (sum > lim) sum = lim;
        if (sum < -lim) sum = -lim;
        integ = sum;
        spd = longint'(kp_m) * err + longint'(ki_m) * sum;
        if (spd > 65536) spd = 65536;
        if (spd < -65536) spd = -65536;
        fwd = (spd >= 0);
        mag = (spd < 0) ? -spd : spd;
        d = (mag * longint'(scale_m) * longint'(fs_m)) >> 32;
        if (d > longint'(fs_m)) d = longint'(fs_m);
        duty = d[DUTY_W-1:0];
        return err;
    endfunction

    function automatic t_result pi_response(input t_item it);
        t_result r;
        longint  le, re, la, ra;
        logic    lf, rf;
        r = '0;
        if (it.kind == KIND_START) begin
            l_goal = it.left_position + it.left_move;
            r_goal = it.right_position + it.right_move;
            l_integ = 0;
            r_integ = 0;
            r.left_forward = ~it.left_move[POS_W-1];
            r.right_forward = ~it.right_move[POS_W-1];
        end else begin
            le = pi_wheel(l_goal, it.left_position, l_integ, lf, l_duty_held);
            re = pi_wheel(r_goal, it.right_position, r_integ, rf, r_duty_held);
            la = (le < 0) ? -le : le;
            ra = (re < 0) ? -re : re;
            r.left_forward = lf;
            r.right_forward = rf;
            r.done_res = (la < longint'(thr_m)) && (ra < longint'(thr_m));
        end
        r.left_duty = l_duty_held;
        r.right_duty = r_duty_held;
        return r;
    endfunction

    function automatic void check_field(input string name, input longint want,
                                        input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_errors++;
        end
    endfunction

    // stimulus side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            drv_gap = 0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (s_axis_tvalid) begin
                motor_cmd_q.push_back(pi_response(drv_item));
                drv_gap = draw_gap();
            end
            if (drv_gap == 0 && move_q.size() != 0) begin
                drv_item = move_q.pop_front();
                s_axis_tdata <= {drv_item.right_move, drv_item.left_move,
                                 drv_item.right_position, drv_item.left_position};
                s_axis_tuser <= drv_item.kind;
                s_axis_tvalid <= 1'b1;
            end else begin
                if (drv_gap != 0) drv_gap--;
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            mon_gap = 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (motor_cmd_q.size() == 0) begin
                    $error("result with none expected: %h", m_axis_tdata);
                    n_errors++;
                end else begin
                    want = motor_cmd_q.pop_front();
                    check_field("left_forward", longint'(want.left_forward),
                                longint'(m_axis_tdata[0]));
                    check_field("right_forward", longint'(want.right_forward),
                                longint'(m_axis_tdata[1]));
                    check_field("left_duty", longint'(want.left_duty),
                                longint'(m_axis_tdata[17:2]));
                    check_field("right_duty", longint'(want.right_duty),
                                longint'(m_axis_tdata[33:18]));
                    check_field("done_res", longint'(want.done_res),
                                longint'(m_axis_tdata[34]));
                    check_field("pad", 0, longint'(m_axis_tdata[39:35]));
                end
                mon_gap = draw_gap();
            end
            if (mon_gap != 0) begin
                mon_gap--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    function automatic void queue_item(input logic kind, input logic [POS_W-1:0] lp,
                                       input logic [POS_W-1:0] rp,
                                       input logic [POS_W-1:0] lm,
                                       input logic [POS_W-1:0] rm);
        t_item it;
        it.kind = kind;
        it.left_position = lp;
        it.right_position = rp;
        it.left_move = lm;
        it.right_move = rm;
        if (kind == KIND_START) begin
            gen_lgoal = lp + lm;
            gen_rgoal = rp + rm;
        end
        move_q.push_back(it);
    endfunction

    // position around the target, mostly close to it
    function automatic logic [POS_W-1:0] near_goal(input logic [POS_W-1:0] goal);
        int unsigned      span;
        logic [POS_W-1:0] off;
        case ($urandom_range(0, 9))
            0, 1, 2: span = 4;
            3, 4:    span = (thr_m < 65000) ? thr_m + 2 : 65000;
            5, 6:    span = 70000;
            7:       span = 2000000;
            8:       return $urandom;
            default: begin
                case ($urandom_range(0, 3))
                    0:       off = 32'h8000_0000;
                    1:       off = 32'h7fff_ffff;
                    2:       off = 32'hffff_ffff;
                    default: off = 32'h0000_0001;
                endcase
                return goal - off;
            end
        endcase
        off = 32'($urandom_range(0, 2 * span)) - span;
        return goal - off;
    endfunction

    function automatic logic [POS_W-1:0] rand_move();
        case ($urandom_range(0, 5))
            0, 1, 2: return 32'($urandom_range(0, 6000)) - 32'd3000;
            3:       return 32'($urandom_range(0, 2000000)) - 32'd1000000;
            4:       return $urandom;
            default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [SCALE_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_PROP_GAIN:   kp_m = val[GAIN_W-1:0];
            CFG_INTEG_GAIN:  ki_m = val[GAIN_W-1:0];
            CFG_INTEG_LIMIT: ilim_m = val[GAIN_W-1:0];
            CFG_SPEED_SCALE: scale_m = val;
            CFG_DUTY_FS:     fs_m = val[GAIN_W-1:0];
            CFG_DONE_THRESH: thr_m = val[GAIN_W-1:0];
            default: ;
        endcase
    endtask

    function automatic logic [SCALE_W-1:0] pick_reg(input logic [SCALE_W-1:0] lo,
                                                    input logic [SCALE_W-1:0] hi,
                                                    input int unsigned typ_lo,
                                                    input int unsigned typ_hi);
        case ($urandom_range(0, 6))
            0:       return lo;
            1:       return hi;
            2:       return SCALE_W'($urandom);
            default: return SCALE_W'($urandom_range(typ_lo, typ_hi));
        endcase
    endfunction

    // mode 0 lowest values (full scale one), 1 highest (speed scale 131072), 2 zero full scale, else mixed
    task automatic set_regs(input int mode);
        case (mode)
            0: begin
                write_reg(CFG_PROP_GAIN, '0);
                write_reg(CFG_INTEG_GAIN, '0);
                write_reg(CFG_INTEG_LIMIT, '0);
                write_reg(CFG_SPEED_SCALE, '0);
                write_reg(CFG_DUTY_FS, 18'd1);
                write_reg(CFG_DONE_THRESH, '0);
            end
            1: begin
                write_reg(CFG_PROP_GAIN, 18'd65535);
                write_reg(CFG_INTEG_GAIN, 18'd65535);
                write_reg(CFG_INTEG_LIMIT, 18'd65535);
                write_reg(CFG_SPEED_SCALE, 18'd131072);
                write_reg(CFG_DUTY_FS, 18'd65535);
                write_reg(CFG_DONE_THRESH, 18'd65535);
            end
            default: begin
                write_reg(CFG_PROP_GAIN, pick_reg('0, 18'd65535, 0, 40000));
                write_reg(CFG_INTEG_GAIN, pick_reg('0, 18'd65535, 0, 2000));
                write_reg(CFG_INTEG_LIMIT, pick_reg('0, 18'd65535, 0, 5000));
                write_reg(CFG_SPEED_SCALE, pick_reg('0, 18'h3ffff, 0, 131072));
                write_reg(CFG_DUTY_FS, (mode == 2) ? '0 : pick_reg(18'd1, 18'd65535, 1, 65535));
                write_reg(CFG_DONE_THRESH, pick_reg('0, 18'd65535, 0, 10));
            end
        endcase
        write_reg(CFG_SPARE_A, SCALE_W'($urandom));
        write_reg(CFG_SPARE_B, SCALE_W'($urandom));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // block until every expected result is back, then let it settle
    task automatic wait_drained();
        while (move_q.size() != 0 || s_axis_tvalid || motor_cmd_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic fill_phase(input int n_items);
        int cnt, run, k;
        cnt = 0;
        while (cnt < n_items) begin
            if ($urandom_range(0, 9) == 0) begin
                // noise: arbitrary item
                queue_item(1'($urandom_range(0, 1)), $urandom, $urandom, $urandom, $urandom);
                cnt++;
            end else begin
                queue_item(KIND_START,
                           $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 4000)),
                           $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 4000)),
                           rand_move(), rand_move());
                cnt++;
                run = $urandom_range(2, 12);
                for (k = 0; k < run && cnt < n_items; k++) begin
                    queue_item(KIND_STEP, near_goal(gen_lgoal), near_goal(gen_rgoal),
                               $urandom, $urandom);
                    cnt++;
                end
            end
        end
    endtask

    initial begin
        int p;
        kp_m = RST_PROP_GAIN;
        ki_m = RST_INTEG_GAIN;
        ilim_m = RST_INTEG_LIMIT;
        scale_m = RST_SPEED_SCALE;
        fs_m = RST_DUTY_FS;
        thr_m = RST_DONE_THRESH;
        l_goal = '0;
        r_goal = '0;
        l_integ = 0;
        r_integ = 0;
        l_duty_held = '0;
        r_duty_held = '0;
        gen_lgoal = '0;
        gen_rgoal = '0;
        n_errors = 0;
        quiet = 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part on the reset register values
        queue_item(KIND_STEP, 32'd5, 32'hffff_fffb, 32'd0, 32'd0);
        queue_item(KIND_START, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_item(KIND_STEP, 32'd0, 32'd0, 32'hffff_ffff, 32'hffff_ffff);
        queue_item(KIND_STEP, 32'd1, 32'hffff_ffff, 32'd0, 32'd0);
        queue_item(KIND_STEP, 32'd2, 32'd0, 32'd0, 32'd0);
        // wrapping targets, both move signs
        queue_item(KIND_START, 32'h7fff_ffff, 32'h8000_0000, 32'd1, 32'hffff_ffff);
        queue_item(KIND_STEP, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_item(KIND_STEP, 32'h8000_0000, 32'h7fff_ffff, 32'd0, 32'd0);
        queue_item(KIND_START, 32'd100, 32'hffff_ff9c, 32'h8000_0000, 32'h7fff_ffff);
        queue_item(KIND_STEP, 32'hffff_ffff, 32'd0, 32'hffff_ffff, 32'hffff_ffff);
        queue_item(KIND_STEP, 32'h0000_0000, 32'hffff_ffff, 32'd0, 32'd0);
        // integral winds up to its limit
        queue_item(KIND_START, 32'd0, 32'd0, 32'd500, 32'hffff_fe0c);
        queue_item(KIND_STEP, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_item(KIND_STEP, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_item(KIND_STEP, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_item(KIND_STEP, 32'd499, 32'hffff_fe0d, 32'd0, 32'd0);
        queue_item(KIND_STEP, 32'd500, 32'hffff_fe0c, 32'd0, 32'd0);
        queue_item(KIND_STEP, 32'd3000, 32'hffff_f448, 32'd0, 32'd0);
        queue_item(KIND_STEP, 32'd500, 32'hffff_fe0c, 32'd0, 32'd0);
        wait_drained();

        // random phases under changing register settings
        for (p = 0; p < N_PHASES; p++) begin
            set_regs(p);
            quiet = (p % 4 == 3);
            fill_phase(PHASE_ITEMS);
            wait_drained();
        end

        if (motor_cmd_q.size() != 0) begin
            $error("%0d expected results never arrived", motor_cmd_q.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
